// ===== src/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, defaults and types for the rotation matrix to quaternion
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int ROT_FRAC_BITS_DEF = 14;
  localparam int ROT_W             = 16;
  localparam int TRANS_W           = 32;
  localparam int QUAT_W            = 16;

  // Enable and valid of one pipeline stage, handed to each sub-pipeline.
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [TRANS_W-1:0] x;
    logic signed [TRANS_W-1:0] y;
    logic signed [TRANS_W-1:0] z;
  } trans_t;

endpackage

`default_nettype wire

// ===== src/rmq_in_if.sv =====
// ----------------------------------------------------------------------------
// rmq_in_if
// Request channel carrying one pose: nine rotation entries and a translation.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmq_pkg::ROT_W-1:0]     r11, r12, r13;
  logic signed [rmq_pkg::ROT_W-1:0]     r21, r22, r23;
  logic signed [rmq_pkg::ROT_W-1:0]     r31, r32, r33;
  logic signed [rmq_pkg::TRANS_W-1:0]   trans_x_in, trans_y_in, trans_z_in;

  modport source (
    output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
           trans_x_in, trans_y_in, trans_z_in,
    input  ready
  );
  modport sink (
    input  valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
           trans_x_in, trans_y_in, trans_z_in,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/rmq_out_if.sv =====
// ----------------------------------------------------------------------------
// rmq_out_if
// Result channel carrying one unit quaternion and the translation.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmq_pkg::QUAT_W-1:0]    quat_a, quat_b, quat_c, quat_d;
  logic signed [rmq_pkg::TRANS_W-1:0]   trans_x_out, trans_y_out, trans_z_out;

  modport source (
    output valid, quat_a, quat_b, quat_c, quat_d,
           trans_x_out, trans_y_out, trans_z_out,
    input  ready
  );
  modport sink (
    input  valid, quat_a, quat_b, quat_c, quat_d,
           trans_x_out, trans_y_out, trans_z_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts the rotation part of a pose into a unit quaternion and passes
// the translation through.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one pose per request (r11..r33 in Q1.F, translation in
//   Q16.16); out_ch returns one quaternion (scalar first, Q1.F) with the
//   untouched translation for every request, in order.
//   The block is a single pipeline with no state between poses: it takes
//   one request per cycle and holds it to one result per cycle.
//   The stages run in order: A, B, the bit-per-stage square root
//   pipeline for the four magnitudes, C, D, a second bit-per-stage square
//   root pipeline for the norm, E, the bit-per-stage divider and the
//   output register.
//   All stages advance together whenever the output register is empty or
//   being taken; while the receiver stalls a full output, the whole
//   pipeline holds and in_ch.ready is low, so nothing is lost or repeated.
//   Reset clears every valid bit; the first request may follow at once.
//   A zero norm, which a real rotation cannot give, yields a zero quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion #(
  parameter int ROT_FRAC_BITS = rmq_pkg::ROT_FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rmq_in_if.sink      in_ch,
  rmq_out_if.source   out_ch
);

  localparam int F     = ROT_FRAC_BITS;
  localparam int SW    = ((F > 17) ? F : 17) + 2;
  localparam int UW    = SW - 1;
  localparam int XW0   = UW + F;
  localparam int XW    = XW0 + (XW0 % 2);
  localparam int MW    = XW / 2;
  localparam int SQW   = 2 * MW + 2;
  localparam int NW    = SQW / 2;
  localparam int QW    = F + 1;
  localparam int NUMW  = MW + F + 1;
  localparam int TW    = 3 * rmq_pkg::TRANS_W;
  localparam int SIDE1 = TW + 4;
  localparam int SIDE2 = 4 * MW + 4 + TW;
  localparam int OW    = QW + rmq_pkg::QUAT_W;
  localparam int RW_   = rmq_pkg::ROT_W;

  logic               en;

  // Stage A: candidates and off-diagonal signs.
  logic signed [SW-1:0] s_a_r [4];
  logic [5:0]           dn_a_r;
  rmq_pkg::trans_t      tr_a_r;
  logic                 vld_a_r;

  // Stage B: dominant choice, final signs, clamped and scaled radicands.
  logic [3:0][XW-1:0]   x_b_r;
  logic [3:0]           neg_b_r;
  rmq_pkg::trans_t      tr_b_r;
  logic                 vld_b_r;

  logic                 vld_m;
  logic [3:0][MW-1:0]   m_m;
  logic [SIDE1-1:0]     side_m;

  // Stage C: squares. Stage D: sum of squares.
  logic [2*MW-1:0]      sq_c_r [4];
  logic [3:0][MW-1:0]   m_c_r;
  logic [SIDE1-1:0]     side_c_r;
  logic                 vld_c_r;
  logic [0:0][SQW-1:0]  sum_d_r;
  logic [3:0][MW-1:0]   m_d_r;
  logic [SIDE1-1:0]     side_d_r;
  logic                 vld_d_r;

  logic                 vld_n;
  logic [0:0][NW-1:0]   n_n;
  logic [SIDE2-1:0]     side_n;
  logic [3:0][MW-1:0]   m_n;
  logic [SIDE1-1:0]     side1_n;

  // Stage E: rounded numerators.
  logic [3:0][NUMW-1:0] num_e_r;
  logic [NW-1:0]        den_e_r;
  logic [SIDE1-1:0]     side_e_r;
  logic                 vld_e_r;

  logic                 vld_q;
  logic [3:0][QW-1:0]   quot_q;
  logic [NW-1:0]        den_q;
  logic [SIDE1-1:0]     side_q;

  // Output register.
  logic [rmq_pkg::QUAT_W-1:0] quat_r [4];
  rmq_pkg::trans_t            tr_o_r;
  logic                       out_vld_r;
  logic [rmq_pkg::QUAT_W-1:0] quat_nxt [4];

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage A ----------------
  logic signed [SW-1:0]   one_s;
  logic signed [SW-1:0]   e11, e22, e33;
  logic signed [RW_:0]    d_32m23, d_13m31, d_21m12, d_21p12, d_13p31, d_32p23;

  assign one_s = SW'(1) << F;
  assign e11   = SW'(in_ch.r11);
  assign e22   = SW'(in_ch.r22);
  assign e33   = SW'(in_ch.r33);
  assign d_32m23 = (RW_+1)'(in_ch.r32) - (RW_+1)'(in_ch.r23);
  assign d_13m31 = (RW_+1)'(in_ch.r13) - (RW_+1)'(in_ch.r31);
  assign d_21m12 = (RW_+1)'(in_ch.r21) - (RW_+1)'(in_ch.r12);
  assign d_21p12 = (RW_+1)'(in_ch.r21) + (RW_+1)'(in_ch.r12);
  assign d_13p31 = (RW_+1)'(in_ch.r13) + (RW_+1)'(in_ch.r31);
  assign d_32p23 = (RW_+1)'(in_ch.r32) + (RW_+1)'(in_ch.r23);

  always_ff @(posedge clk) begin
    if (en) begin
      s_a_r[0] <= one_s + e11 + e22 + e33;
      s_a_r[1] <= one_s + e11 - e22 - e33;
      s_a_r[2] <= one_s - e11 + e22 - e33;
      s_a_r[3] <= one_s - e11 - e22 + e33;
      dn_a_r   <= {d_32p23[RW_], d_13p31[RW_], d_21p12[RW_],
                   d_21m12[RW_], d_13m31[RW_], d_32m23[RW_]};
      tr_a_r   <= '{x: in_ch.trans_x_in, y: in_ch.trans_y_in, z: in_ch.trans_z_in};
    end
  end

  // ---------------- stage B ----------------
  logic [3:0]         neg_b_nxt;
  logic [3:0][XW-1:0] x_b_nxt;

  always_comb begin
    logic n32m23, n13m31, n21m12, n21p12, n13p31, n32p23;
    {n32p23, n13p31, n21p12, n21m12, n13m31, n32m23} = dn_a_r;
    // The first candidate not below the other three is dominant.
    if (s_a_r[0] >= s_a_r[1] && s_a_r[0] >= s_a_r[2] && s_a_r[0] >= s_a_r[3]) begin
      neg_b_nxt = {n21m12, n13m31, n32m23, 1'b0};
    end else if (s_a_r[1] >= s_a_r[2] && s_a_r[1] >= s_a_r[3]) begin
      neg_b_nxt = {n13p31, n21p12, 1'b0, n32m23};
    end else if (s_a_r[2] >= s_a_r[3]) begin
      neg_b_nxt = {n32p23, 1'b0, n21p12, n13m31};
    end else begin
      neg_b_nxt = {1'b0, n32p23, n13p31, n21m12};
    end
    for (int i = 0; i < 4; i++) begin
      if (s_a_r[i][SW-1]) begin
        x_b_nxt[i] = '0;
      end else begin
        x_b_nxt[i] = XW'(s_a_r[i][UW-1:0]) << F;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_b_r   <= x_b_nxt;
      neg_b_r <= neg_b_nxt;
      tr_b_r  <= tr_a_r;
    end
  end

  // ---------------- magnitudes ----------------
  rmq_pkg::pipe_ctl_t ctl_m;
  assign ctl_m = '{en: en, valid: vld_b_r};

  rmq_isqrt_pipe #(.LANES(4), .XW(XW), .SIDE_W(SIDE1)) u_mag_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_m),
    .x_i     (x_b_r),
    .side_i  ({neg_b_r, tr_b_r}),
    .valid_o (vld_m),
    .root_o  (m_m),
    .side_o  (side_m)
  );

  // ---------------- stages C and D ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq_c_r[i] <= (2*MW)'(m_m[i]) * (2*MW)'(m_m[i]);
      end
      m_c_r    <= m_m;
      side_c_r <= side_m;
      sum_d_r[0] <= SQW'(sq_c_r[0]) + SQW'(sq_c_r[1]) + SQW'(sq_c_r[2]) + SQW'(sq_c_r[3]);
      m_d_r    <= m_c_r;
      side_d_r <= side_c_r;
    end
  end

  // ---------------- norm ----------------
  rmq_pkg::pipe_ctl_t ctl_n;
  assign ctl_n = '{en: en, valid: vld_d_r};

  rmq_isqrt_pipe #(.LANES(1), .XW(SQW), .SIDE_W(SIDE2)) u_norm_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_n),
    .x_i     (sum_d_r),
    .side_i  ({m_d_r, side_d_r}),
    .valid_o (vld_n),
    .root_o  (n_n),
    .side_o  (side_n)
  );

  assign {m_n, side1_n} = side_n;

  // ---------------- stage E ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        num_e_r[i] <= (NUMW'(m_n[i]) << F) + NUMW'(n_n[0] >> 1);
      end
      den_e_r  <= n_n[0];
      side_e_r <= side1_n;
    end
  end

  // ---------------- division ----------------
  rmq_pkg::pipe_ctl_t ctl_q;
  assign ctl_q = '{en: en, valid: vld_e_r};

  rmq_div_pipe #(
    .LANES(4), .NUMW(NUMW), .NW(NW), .QW(QW), .SIDE_W(SIDE1)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_q),
    .num_i   (num_e_r),
    .den_i   (den_e_r),
    .side_i  (side_e_r),
    .valid_o (vld_q),
    .quot_o  (quot_q),
    .den_o   (den_q),
    .side_o  (side_q)
  );

  // ---------------- output stage ----------------
  logic [3:0]      neg_q;
  rmq_pkg::trans_t tr_q;
  assign {neg_q, tr_q} = side_q;

  always_comb begin
    logic [QW-1:0] q;
    logic [OW-1:0] qe;
    for (int i = 0; i < 4; i++) begin
      q = quot_q[i];
      if (q > (QW'(1) << F)) begin
        q = QW'(1) << F;
      end
      if (den_q == '0) begin
        q = '0;
      end
      qe = OW'(q);
      if (neg_q[i]) begin
        qe = -qe;
      end
      quat_nxt[i] = qe[rmq_pkg::QUAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_r <= quat_nxt;
      tr_o_r <= tr_q;
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r   <= 1'b0;
      vld_b_r   <= 1'b0;
      vld_c_r   <= 1'b0;
      vld_d_r   <= 1'b0;
      vld_e_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_a_r   <= in_ch.valid;
      vld_b_r   <= vld_a_r;
      vld_c_r   <= vld_m;
      vld_d_r   <= vld_c_r;
      vld_e_r   <= vld_n;
      out_vld_r <= vld_q;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.quat_a      = quat_r[0];
  assign out_ch.quat_b      = quat_r[1];
  assign out_ch.quat_c      = quat_r[2];
  assign out_ch.quat_d      = quat_r[3];
  assign out_ch.trans_x_out = tr_o_r.x;
  assign out_ch.trans_y_out = tr_o_r.y;
  assign out_ch.trans_z_out = tr_o_r.z;

`ifndef SYNTHESIS
  // The pipeline only holds when a finished result is being refused.
  a_hold_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> (out_vld_r && !out_ch.ready))
    else $error("pipeline held without a stalled result");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !vld_a_r && !vld_e_r)
    else $error("valid bits not cleared by reset");

  // A valid request in stage A is carried into stage B on the next move.
  a_stage_ab: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_a_r && en) |=> vld_b_r)
    else $error("request lost between the first two stages");

  a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (F > 14) ||
      (int'(out_ch.quat_a) <= (1 << F) && int'(out_ch.quat_a) >= -(1 << F) &&
       int'(out_ch.quat_d) <= (1 << F) && int'(out_ch.quat_d) >= -(1 << F)))
    else $error("quaternion component out of range");
`endif

endmodule

`default_nettype wire

// ===== src/rmq_isqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// rmq_isqrt_pipe
// Pipelined integer square root, one result bit per stage, several lanes
// in step, with a side payload that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_isqrt_pipe #(
  parameter int LANES  = 4,
  parameter int XW     = 32,
  parameter int SIDE_W = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rmq_pkg::pipe_ctl_t            ctl_i,
  input  wire logic [LANES-1:0][XW-1:0]      x_i,
  input  wire logic [SIDE_W-1:0]             side_i,
  output logic                               valid_o,
  output logic [LANES-1:0][XW/2-1:0]         root_o,
  output logic [SIDE_W-1:0]                  side_o
);

  localparam int RW = XW / 2;
  localparam int PW = RW + 4;

  logic [LANES-1:0][XW-1:0]   xs_r   [RW];
  logic [LANES-1:0][RW+1:0]   rem_r  [RW];
  logic [LANES-1:0][RW-1:0]   root_r [RW];
  logic [SIDE_W-1:0]          side_r [RW];
  logic [RW-1:0]              vld_r;

  logic [LANES-1:0][XW-1:0]   xs_nxt   [RW];
  logic [LANES-1:0][RW+1:0]   rem_nxt  [RW];
  logic [LANES-1:0][RW-1:0]   root_nxt [RW];
  logic [SIDE_W-1:0]          side_nxt [RW];
  logic [RW-1:0]              vld_nxt;

  always_comb begin
    logic [LANES-1:0][XW-1:0] xs_src;
    logic [LANES-1:0][RW+1:0] rem_src;
    logic [LANES-1:0][RW-1:0] root_src;
    logic [PW-1:0]            rp;
    logic [PW-1:0]            trial;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        xs_src      = x_i;
        rem_src     = '0;
        root_src    = '0;
        side_nxt[k] = side_i;
        vld_nxt[k]  = ctl_i.valid;
      end else begin
        xs_src      = xs_r[k-1];
        rem_src     = rem_r[k-1];
        root_src    = root_r[k-1];
        side_nxt[k] = side_r[k-1];
        vld_nxt[k]  = vld_r[k-1];
      end
      for (int l = 0; l < LANES; l++) begin
        // Bring down the next two bits and try root*4+1 against them.
        rp    = {rem_src[l], xs_src[l][XW-1 -: 2]};
        trial = PW'({root_src[l], 2'b01});
        xs_nxt[k][l] = {xs_src[l][XW-3:0], 2'b00};
        if (rp >= trial) begin
          rem_nxt[k][l]  = (RW+2)'(rp - trial);
          root_nxt[k][l] = {root_src[l][RW-2:0], 1'b1};
        end else begin
          rem_nxt[k][l]  = (RW+2)'(rp);
          root_nxt[k][l] = {root_src[l][RW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl_i.en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int k = 0; k < RW; k++) begin
        xs_r[k]   <= xs_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign valid_o = vld_r[RW-1];
  assign root_o  = root_r[RW-1];
  assign side_o  = side_r[RW-1];

endmodule

`default_nettype wire

// ===== src/rmq_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rmq_div_pipe
// Pipelined restoring divider, one quotient bit per stage, several
// numerators over one shared divisor. The numerator must stay below
// divisor * 2^QW.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div_pipe #(
  parameter int LANES  = 4,
  parameter int NUMW   = 32,
  parameter int NW     = 17,
  parameter int QW     = 15,
  parameter int SIDE_W = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rmq_pkg::pipe_ctl_t            ctl_i,
  input  wire logic [LANES-1:0][NUMW-1:0]    num_i,
  input  wire logic [NW-1:0]                 den_i,
  input  wire logic [SIDE_W-1:0]             side_i,
  output logic                               valid_o,
  output logic [LANES-1:0][QW-1:0]           quot_o,
  output logic [NW-1:0]                      den_o,
  output logic [SIDE_W-1:0]                  side_o
);

  localparam int DW = NW + QW;

  logic [LANES-1:0][DW-1:0]   rem_r  [QW];
  logic [LANES-1:0][QW-1:0]   quot_r [QW];
  logic [NW-1:0]              den_r  [QW];
  logic [SIDE_W-1:0]          side_r [QW];
  logic [QW-1:0]              vld_r;

  logic [LANES-1:0][DW-1:0]   rem_nxt  [QW];
  logic [LANES-1:0][QW-1:0]   quot_nxt [QW];
  logic [NW-1:0]              den_nxt  [QW];
  logic [SIDE_W-1:0]          side_nxt [QW];
  logic [QW-1:0]              vld_nxt;

  always_comb begin
    logic [LANES-1:0][DW-1:0] rem_src;
    logic [LANES-1:0][QW-1:0] quot_src;
    logic [DW-1:0]            dsh;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        for (int l = 0; l < LANES; l++) begin
          rem_src[l] = DW'(num_i[l]);
        end
        quot_src    = '0;
        den_nxt[k]  = den_i;
        side_nxt[k] = side_i;
        vld_nxt[k]  = ctl_i.valid;
      end else begin
        rem_src     = rem_r[k-1];
        quot_src    = quot_r[k-1];
        den_nxt[k]  = den_r[k-1];
        side_nxt[k] = side_r[k-1];
        vld_nxt[k]  = vld_r[k-1];
      end
      // Stage k settles quotient bit QW-1-k.
      dsh = DW'(den_nxt[k]) << (QW - 1 - k);
      for (int l = 0; l < LANES; l++) begin
        if (rem_src[l] >= dsh) begin
          rem_nxt[k][l]  = rem_src[l] - dsh;
          quot_nxt[k][l] = quot_src[l] | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_nxt[k][l]  = rem_src[l];
          quot_nxt[k][l] = quot_src[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl_i.en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        quot_r[k] <= quot_nxt[k];
        den_r[k]  <= den_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign valid_o = vld_r[QW-1];
  assign quot_o  = quot_r[QW-1];
  assign den_o   = den_r[QW-1];
  assign side_o  = side_r[QW-1];

endmodule

`default_nettype wire

// ===== dv/tb_rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Drives poses into the quaternion pipeline, predicts each quaternion and
// the passed-through translation, and checks every result in order, with
// random stalls on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rotation_matrix_to_quaternion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = rmq_pkg::ROT_FRAC_BITS_DEF;
  localparam int RW   = rmq_pkg::ROT_W;
  localparam int TRW  = rmq_pkg::TRANS_W;
  localparam int QTW  = rmq_pkg::QUAT_W;
  localparam int LAT  = 54;

  typedef struct packed {
    logic signed [RW-1:0] r11, r12, r13, r21, r22, r23, r31, r32, r33;
    logic signed [TRW-1:0] tx, ty, tz;
  } pose_t;

  typedef struct packed {
    logic signed [QTW-1:0] qa, qb, qc, qd;
    logic signed [TRW-1:0] tx, ty, tz;
  } quat_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  pose_t     pose_queue[$];
  quat_res_t quat_expected[$];
  int        errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  bit        quiet = 1'b0;
  bit        hold_tx = 1'b0;
  bit        rx_stall = 1'b0;
  int        tx_gap = 0;
  int        rx_gap = 0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic quat_res_t pose_to_quat(pose_t p);
    longint cand[4];
    longint unsigned mag[4], sumsq, nrm, q;
    bit negs[4];
    int dom;
    logic [QTW-1:0] comp[4];
    quat_res_t r;
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33, one;
    a11 = p.r11; a12 = p.r12; a13 = p.r13;
    a21 = p.r21; a22 = p.r22; a23 = p.r23;
    a31 = p.r31; a32 = p.r32; a33 = p.r33;
    one = 64'sd1 << FRAC;
    cand[0] = one + a11 + a22 + a33;
    cand[1] = one + a11 - a22 - a33;
    cand[2] = one - a11 + a22 - a33;
    cand[3] = one - a11 - a22 + a33;
    sumsq = 0;
    for (int i = 0; i < 4; i++) begin
      if (cand[i] < 0) cand[i] = 0;
      mag[i] = int_sqrt(longint'(cand[i]) << FRAC);
      sumsq += mag[i] * mag[i];
      negs[i] = 1'b0;
    end
    // Ties go to the lowest index.
    if (cand[0] >= cand[1] && cand[0] >= cand[2] && cand[0] >= cand[3]) dom = 0;
    else if (cand[1] >= cand[2] && cand[1] >= cand[3]) dom = 1;
    else if (cand[2] >= cand[3]) dom = 2;
    else dom = 3;
    case (dom)
      0: begin
        negs[1] = (a32 - a23) < 0; negs[2] = (a13 - a31) < 0; negs[3] = (a21 - a12) < 0;
      end
      1: begin
        negs[0] = (a32 - a23) < 0; negs[2] = (a21 + a12) < 0; negs[3] = (a13 + a31) < 0;
      end
      2: begin
        negs[0] = (a13 - a31) < 0; negs[1] = (a21 + a12) < 0; negs[3] = (a32 + a23) < 0;
      end
      default: begin
        negs[0] = (a21 - a12) < 0; negs[1] = (a31 + a13) < 0; negs[2] = (a32 + a23) < 0;
      end
    endcase
    nrm = int_sqrt(sumsq);
    for (int i = 0; i < 4; i++) begin
      q = 0;
      if (nrm != 0) begin
        q = ((mag[i] << FRAC) + (nrm >> 1)) / nrm;
        if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
      end
      if (negs[i]) q = -q;
      comp[i] = q[QTW-1:0];
    end
    r.qa = comp[0]; r.qb = comp[1]; r.qc = comp[2]; r.qd = comp[3];
    r.tx = p.tx; r.ty = p.ty; r.tz = p.tz;
    return r;
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    p.r11 = RW'($urandom); p.r12 = RW'($urandom); p.r13 = RW'($urandom);
    p.r21 = RW'($urandom); p.r22 = RW'($urandom); p.r23 = RW'($urandom);
    p.r31 = RW'($urandom); p.r32 = RW'($urandom); p.r33 = RW'($urandom);
    p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
    return p;
  endfunction

  // Roughly orthonormal rotations: a signed permutation with small noise,
  // so that every dominant component and every sign pattern is reached.
  function automatic pose_t near_rotation();
    pose_t p;
    logic signed [RW-1:0] m[9];
    int perm[3];
    int k, t;
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      k = $urandom_range(i, 0);
      t = perm[i]; perm[i] = perm[k]; perm[k] = t;
    end
    for (int i = 0; i < 9; i++) m[i] = RW'(int'($urandom_range(2000, 0)) - 1000);
    for (int i = 0; i < 3; i++)
      m[i*3 + perm[i]] = $urandom_range(1) ? RW'(16384 - int'($urandom_range(3000, 0)))
                                           : RW'(int'($urandom_range(3000, 0)) - 16384);
    p = random_pose();
    {p.r11, p.r12, p.r13, p.r21, p.r22, p.r23, p.r31, p.r32, p.r33} =
      {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    return p;
  endfunction

  function automatic pose_t diag_pose(int d11, int d22, int d33, int off);
    pose_t p;
    p = '0;
    p.r11 = RW'(d11); p.r22 = RW'(d22); p.r33 = RW'(d33);
    p.r12 = RW'(off); p.r13 = RW'(-off); p.r21 = RW'(-off);
    p.r23 = RW'(off); p.r31 = RW'(off); p.r32 = RW'(-off);
    return p;
  endfunction

  // Driver: offers the head of the pending queue, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        quat_expected.push_back(pose_to_quat(pose_queue.pop_front()));
        n_sent++;
      end
      // A request that has not been taken stays on the bus unchanged.
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) tx_gap--;
        else if (!quiet && $urandom_range(9) == 0) tx_gap = $urandom_range(10, 1);
        if (pose_queue.size() > 0 && tx_gap == 0 && !hold_tx) begin
          in_ch.valid <= 1'b1;
          {in_ch.r11, in_ch.r12, in_ch.r13, in_ch.r21, in_ch.r22, in_ch.r23,
           in_ch.r31, in_ch.r32, in_ch.r33, in_ch.trans_x_in, in_ch.trans_y_in,
           in_ch.trans_z_in} <= pose_queue[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction.
  always @(posedge clk) begin
    quat_res_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.quat_a, out_ch.quat_b, out_ch.quat_c, out_ch.quat_d,
               out_ch.trans_x_out, out_ch.trans_y_out, out_ch.trans_z_out};
        if (quat_expected.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, got);
          errors++;
        end else begin
          want = quat_expected.pop_front();
          n_checked++;
          if (got.qa !== want.qa) begin
            $display("%0t: quat_a expected %0d got %0d", $time, want.qa, got.qa); errors++;
          end
          if (got.qb !== want.qb) begin
            $display("%0t: quat_b expected %0d got %0d", $time, want.qb, got.qb); errors++;
          end
          if (got.qc !== want.qc) begin
            $display("%0t: quat_c expected %0d got %0d", $time, want.qc, got.qc); errors++;
          end
          if (got.qd !== want.qd) begin
            $display("%0t: quat_d expected %0d got %0d", $time, want.qd, got.qd); errors++;
          end
          if (got.tx !== want.tx) begin
            $display("%0t: trans_x expected %h got %h", $time, want.tx, got.tx); errors++;
          end
          if (got.ty !== want.ty) begin
            $display("%0t: trans_y expected %h got %h", $time, want.ty, got.ty); errors++;
          end
          if (got.tz !== want.tz) begin
            $display("%0t: trans_z expected %h got %h", $time, want.tz, got.tz); errors++;
          end
        end
      end
      if (rx_stall) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_gap > 0) rx_gap--;
        else if (!quiet && $urandom_range(9) == 0) rx_gap = $urandom_range(10, 1);
        out_ch.ready <= (rx_gap == 0);
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering.
  initial begin
    wait (n_sent >= 20);
    @(posedge clk);
    rx_stall <= 1'b1;
    repeat (200) @(posedge clk);
    rx_stall <= 1'b0;
  end

  initial begin
    int wait_cycles;
    in_ch.valid = 1'b0;
    in_ch.r11 = '0; in_ch.r12 = '0; in_ch.r13 = '0;
    in_ch.r21 = '0; in_ch.r22 = '0; in_ch.r23 = '0;
    in_ch.r31 = '0; in_ch.r32 = '0; in_ch.r33 = '0;
    in_ch.trans_x_in = '0; in_ch.trans_y_in = '0; in_ch.trans_z_in = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed poses: identity, each axis dominant, ties, clamped candidates,
    // all-zero and all-extreme entries.
    pose_queue.push_back(diag_pose(16384, 16384, 16384, 0));
    pose_queue.push_back(diag_pose(16384, -16384, -16384, 0));
    pose_queue.push_back(diag_pose(-16384, 16384, -16384, 0));
    pose_queue.push_back(diag_pose(-16384, -16384, 16384, 0));
    pose_queue.push_back(diag_pose(16384, -16384, -16384, 500));
    pose_queue.push_back(diag_pose(-16384, 16384, -16384, -500));
    pose_queue.push_back(diag_pose(-16384, -16384, 16384, 700));
    pose_queue.push_back(diag_pose(0, 0, 0, 0));
    pose_queue.push_back(diag_pose(0, 0, 0, 1000));
    pose_queue.push_back(diag_pose(-16384, -16384, -16384, 0));
    pose_queue.push_back(diag_pose(-32768, -32768, -32768, -32768));
    pose_queue.push_back(diag_pose(32767, 32767, 32767, 32767));
    pose_queue.push_back(diag_pose(32767, -32768, -32768, 32767));
    pose_queue.push_back(diag_pose(-32768, 32767, -32768, -32768));
    pose_queue.push_back(diag_pose(-32768, -32768, 32767, 1));
    pose_queue.push_back(diag_pose(5461, 5461, 5461, 0));
    begin
      pose_t p;
      p = '1; pose_queue.push_back(p);
      p = '0; p.tx = 32'h8000_0000; p.ty = 32'h7fff_ffff; p.tz = '1;
      pose_queue.push_back(p);
    end
    repeat (80) pose_queue.push_back(near_rotation());

    wait (pose_queue.size() == 0);

    // Sender pauses until the pipeline is drained.
    hold_tx = 1'b1;
    wait (quat_expected.size() == 0);
    hold_tx = 1'b0;

    for (int i = 0; i < 450; i++)
      pose_queue.push_back($urandom_range(3) == 0 ? random_pose() : near_rotation());
    wait (pose_queue.size() < 80);
    quiet = 1'b1;
    wait (pose_queue.size() == 0);
    wait (quat_expected.size() == 0);
    wait_cycles = 0;
    while (wait_cycles < 2 * LAT) begin
      @(posedge clk);
      wait_cycles++;
    end
    $display("Checked %0d of %0d poses: axis-aligned, near-rotation and arbitrary",
             n_checked, n_sent);
    $display("entries, under random stalls on both channels and a long output hold-off.");
    if (errors == 0) begin
      $display("PASS rotation_matrix_to_quaternion");
    end else begin
      $display("FAIL rotation_matrix_to_quaternion");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL rotation_matrix_to_quaternion");
    $finish;
  end

endmodule

`default_nettype wire
